>>> design/sdcb_pkg.sv
// Shared types and constants of the disk command builder.
// Used by sdcb_ctrl, sdcb_datapath and sata_dma_command_builder_core.
package sdcb_pkg;

  localparam int MAX_PRD_ENTRIES = 8;
  localparam int ENTRY_LOG2      = 13;
  localparam int ENTRY_BYTES     = 1 << ENTRY_LOG2;
  localparam int IDX_W           = $clog2(MAX_PRD_ENTRIES);
  localparam int BYTE_W          = 13;
  localparam int SECT_LG_MIN     = 9;
  localparam int SECT_LG_MAX     = 13;
  localparam int NUM_SLOTS       = 32;
  localparam int IDENT_BYTES_M1  = 512 - 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR64           = 2'd2;

  localparam logic [1:0] OP_IDENTIFY = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_WRITE    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] ST_ISSUED   = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;

  localparam logic [7:0] ATA_IDENTIFY  = 8'hEC;
  localparam logic [7:0] ATA_READ_EXT  = 8'h25;
  localparam logic [7:0] ATA_WRITE_EXT = 8'h35;

  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
  } sdcb_cmd_t;

  typedef struct packed {
    logic drop;
    logic last;
  } sdcb_stat_t;

endpackage

>>> design/sdcb_datapath.sv
// Datapath of the disk command builder: configuration registers, request
// registers, slot search, entry sizing and the result register. Uses sdcb_pkg.
module sdcb_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sdcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdcb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [1:0]                          in_operation,
  input  logic [47:0]                         in_start_block,
  input  logic [15:0]                         in_sector_total,
  input  logic [63:0]                         in_buffer_address,
  input  logic [31:0]                         in_busy_slots,
  input  sdcb_pkg::sdcb_cmd_t                 cmd,
  output sdcb_pkg::sdcb_stat_t                stat,
  output logic [1:0]                          out_status,
  output logic [4:0]                          out_slot,
  output logic [2:0]                          out_entry_index,
  output logic [63:0]                         out_entry_address,
  output logic [12:0]                         out_entry_byte_count,
  output logic [15:0]                         out_entry_total,
  output logic [7:0]                          out_ata_command,
  output logic                                out_write_dir,
  output logic [47:0]                         out_block_out,
  output logic [15:0]                         out_count_out,
  output logic                                out_last
);
  import sdcb_pkg::*;

  typedef enum logic [1:0] {
    K_NO_SLOT,
    K_IDENT,
    K_TOO_MANY,
    K_DATA
  } kind_t;

  logic [3:0]  sect_lg_r;
  logic [5:0]  slot_cnt_r;
  logic        addr64_r;

  logic [1:0]  op_r;
  logic [47:0] blk_r;
  logic [15:0] cnt_r;
  logic [63:0] buf_r;
  logic [31:0] busy_r;

  kind_t             kind_r;
  logic [4:0]        slot_r;
  logic [15:0]       entries_r;
  logic [BYTE_W-1:0] lastb_r;
  logic [IDX_W-1:0]  idx_r;
  logic [63:0]       addr_r;

  logic [31:0]       slot_mask;
  logic [31:0]       free_c;
  logic [4:0]        slot_c;
  logic              found_c;
  logic [3:0]        lg_c;
  logic [3:0]        sh_c;
  logic [15:0]       cnt_m1;
  logic [15:0]       spe_mask;
  logic [15:0]       entries_c;
  logic [15:0]       rem_c;
  logic [31:0]       rem_bytes;
  kind_t             kind_c;
  logic              data_last;

  logic [1:0]        st_c;
  logic [4:0]        slot_o;
  logic [2:0]        idx_o;
  logic [63:0]       addr_o;
  logic [12:0]       bytes_o;
  logic [15:0]       total_o;
  logic [7:0]        ata_o;
  logic              wr_o;
  logic [47:0]       blk_o;
  logic [15:0]       cnt_o;
  logic              last_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sect_lg_r  <= 4'(SECT_LG_MIN);
      slot_cnt_r <= 6'(NUM_SLOTS);
      addr64_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SECTOR_SIZE_LOG2: sect_lg_r  <= cfg_wdata[3:0];
        CFG_SLOT_COUNT:       slot_cnt_r <= cfg_wdata;
        CFG_ADDR64:           addr64_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_mask[i] = (6'(i) < slot_cnt_r);
    end
    free_c  = ~busy_r & slot_mask;
    slot_c  = '0;
    found_c = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_c[i]) begin
        slot_c  = 5'(i);
        found_c = 1'b1;
      end
    end

    if (sect_lg_r < 4'(SECT_LG_MIN)) lg_c = 4'(SECT_LG_MIN);
    else if (sect_lg_r > 4'(SECT_LG_MAX)) lg_c = 4'(SECT_LG_MAX);
    else lg_c = sect_lg_r;
    sh_c      = (lg_c >= 4'(ENTRY_LOG2)) ? 4'd0 : 4'(ENTRY_LOG2) - lg_c;
    cnt_m1    = cnt_r - 16'd1;
    spe_mask  = (16'd1 << sh_c) - 16'd1;
    entries_c = (cnt_m1 >> sh_c) + 16'd1;
    rem_c     = (cnt_m1 & spe_mask) + 16'd1;
    rem_bytes = (32'(rem_c) << lg_c) - 32'd1;

    if (!found_c) kind_c = K_NO_SLOT;
    else if (op_r == OP_IDENTIFY) kind_c = K_IDENT;
    else if (cnt_r == 16'd0 || entries_c > 16'(MAX_PRD_ENTRIES)) kind_c = K_TOO_MANY;
    else kind_c = K_DATA;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      blk_r  <= in_start_block;
      cnt_r  <= in_sector_total;
      buf_r  <= in_buffer_address;
      busy_r <= in_busy_slots;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      kind_r    <= kind_c;
      slot_r    <= slot_c;
      entries_r <= (cnt_r == 16'd0) ? 16'd0 : entries_c;
      lastb_r   <= rem_bytes[BYTE_W-1:0];
      idx_r     <= '0;
      addr_r    <= buf_r;
    end else if (cmd.emit) begin
      idx_r     <= idx_r + IDX_W'(1);
      addr_r    <= addr_r + 64'(ENTRY_BYTES);
    end
  end

  assign data_last = ((16'(idx_r) + 16'd1) == entries_r);
  assign stat.drop = (in_operation == OP_RESERVED);
  assign stat.last = (kind_r != K_DATA) || data_last;

  always_comb begin
    st_c    = ST_ISSUED;
    slot_o  = slot_r;
    idx_o   = '0;
    addr_o  = '0;
    bytes_o = '0;
    total_o = '0;
    ata_o   = '0;
    wr_o    = 1'b0;
    blk_o   = '0;
    cnt_o   = '0;
    last_o  = 1'b1;
    case (kind_r)
      K_NO_SLOT: begin
        st_c   = ST_NO_SLOT;
        slot_o = '0;
      end
      K_IDENT: begin
        addr_o  = addr64_r ? buf_r : {32'd0, buf_r[31:0]};
        bytes_o = 13'(IDENT_BYTES_M1);
        total_o = 16'd1;
        ata_o   = ATA_IDENTIFY;
      end
      K_TOO_MANY: begin
        st_c    = ST_TOO_MANY;
        total_o = entries_r;
      end
      K_DATA: begin
        idx_o   = 3'(idx_r);
        addr_o  = addr64_r ? addr_r : {32'd0, addr_r[31:0]};
        bytes_o = data_last ? lastb_r : 13'(ENTRY_BYTES - 1);
        total_o = entries_r;
        wr_o    = (op_r == OP_WRITE);
        ata_o   = (op_r == OP_WRITE) ? ATA_WRITE_EXT : ATA_READ_EXT;
        blk_o   = blk_r;
        cnt_o   = cnt_r;
        last_o  = data_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status           <= st_c;
      out_slot             <= slot_o;
      out_entry_index      <= idx_o;
      out_entry_address    <= addr_o;
      out_entry_byte_count <= bytes_o;
      out_entry_total      <= total_o;
      out_ata_command      <= ata_o;
      out_write_dir        <= wr_o;
      out_block_out        <= blk_o;
      out_count_out        <= cnt_o;
      out_last             <= last_o;
    end
  end

endmodule

>>> design/sdcb_ctrl.sv
// Controller of the disk command builder: request handshake, sequencing of
// setup and per-entry results, result valid. Uses sdcb_pkg.
module sdcb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sdcb_pkg::sdcb_stat_t stat,
  output sdcb_pkg::sdcb_cmd_t  cmd
);
  import sdcb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !stat.drop) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_setup_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SETUP |=> state_r == S_EMIT)
    else $error("setup not followed by emit");

  a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !stat.drop) |=> state_r == S_SETUP)
    else $error("accepted request not set up");

  a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !stat.last) |=> state_r == S_EMIT)
    else $error("request ended before its last entry");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted entry not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.emit)
    else $error("pending result overwritten");
`endif

endmodule

>>> design/sata_dma_command_builder_core.sv
// Top level of the disk command builder: controller plus datapath.
// Depends on sdcb_pkg, sdcb_ctrl and sdcb_datapath.
//
// One request (identify, read DMA ext or write DMA ext) is taken at a time. The
// block picks the lowest free command slot below the configured slot count and
// gives one result per 8 KiB scatter entry, or a single identify or error
// result. The idle state takes a request, the setup state registers the slot
// search and entry sizing, and the emit state gives one result per cycle from
// the result register unless the output stalls. A stalled result holds the
// result register and pauses the sequence; after the last result is registered
// the next request is taken even while that result still waits. Operation
// code 3 is dropped without a result. Configuration writes must be made by the
// user only while no request is in flight; the block does not enforce this.
module sata_dma_command_builder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sdcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_operation,
  input  logic [47:0]                     in_start_block,
  input  logic [15:0]                     in_sector_total,
  input  logic [63:0]                     in_buffer_address,
  input  logic [31:0]                     in_busy_slots,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [4:0]                      out_slot,
  output logic [2:0]                      out_entry_index,
  output logic [63:0]                     out_entry_address,
  output logic [12:0]                     out_entry_byte_count,
  output logic [15:0]                     out_entry_total,
  output logic [7:0]                      out_ata_command,
  output logic                            out_write_dir,
  output logic [47:0]                     out_block_out,
  output logic [15:0]                     out_count_out,
  output logic                            out_last
);
  import sdcb_pkg::*;

  sdcb_cmd_t  cmd;
  sdcb_stat_t stat;

  sdcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdcb_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_operation         (in_operation),
    .in_start_block       (in_start_block),
    .in_sector_total      (in_sector_total),
    .in_buffer_address    (in_buffer_address),
    .in_busy_slots        (in_busy_slots),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_status           (out_status),
    .out_slot             (out_slot),
    .out_entry_index      (out_entry_index),
    .out_entry_address    (out_entry_address),
    .out_entry_byte_count (out_entry_byte_count),
    .out_entry_total      (out_entry_total),
    .out_ata_command      (out_ata_command),
    .out_write_dir        (out_write_dir),
    .out_block_out        (out_block_out),
    .out_count_out        (out_count_out),
    .out_last             (out_last)
  );

endmodule
